@@ hdl/fcct_pkg.sv @@
package fcct_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int CFG_W             = 13;
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 13'd4096;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int CL_W     = 28;
    localparam int RAW_W    = 32;
    localparam int LEN_W    = 32;

    localparam logic [CL_W-1:0]  LOW28     = 28'hFFFFFFF;
    localparam logic [RAW_W-1:0] TOP4      = 32'hF0000000;
    localparam logic [CL_W-1:0]  BAD_MARK  = 28'hFFFFFF7;
    localparam logic [CL_W-1:0]  FREE_MARK = 28'h0000000;

    localparam logic [FUNC_W-1:0] FN_GET_NEXT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET_NEXT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FINAL    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FREE     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_LOAD     = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ     = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EOC      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LINKED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd7;

endpackage

@@ hdl/fcct_mem.sv @@
module fcct_mem #(
    parameter int DEPTH = fcct_pkg::TABLE_ENTRIES_DEF,
    parameter int AW    = $clog2(fcct_pkg::TABLE_ENTRIES_DEF)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [fcct_pkg::RAW_W-1:0]   wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [fcct_pkg::RAW_W-1:0]   rdata
);

    logic [fcct_pkg::RAW_W-1:0] mem [DEPTH];
    logic [fcct_pkg::RAW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/fat32_cluster_chain_table.sv @@
// fat32 allocation table of TABLE_ENTRIES 32-bit entries in one synchronous ram. after reset
// a clearing pass writes every entry to zero, one per cycle, and busy stays high until it
// is through (config writes are taken meanwhile). a transaction is taken when start
// is high and busy is low; its result shows on the result ports for one cycle with done high
// and cannot be held off. get next, set next, mark final/free, load and read raw each do one
// ram read, then an exec step that writes the entry back if needed; busy drops as the
// result shows, so a new start may come in that same cycle. a cluster out of range or an
// unused func answers in the next cycle without touching the ram. allocate walks the ram one
// entry per cycle over entries 0 to L-1, with L = min(entries_in_use, TABLE_ENTRIES), and
// ends at the first free one or at the end of that range.
module fat32_cluster_chain_table #(
    parameter int TABLE_ENTRIES = fcct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fcct_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic [fcct_pkg::FUNC_W-1:0]     func,
    input  logic [fcct_pkg::CL_W-1:0]       cluster,
    input  logic [fcct_pkg::CL_W-1:0]       target,
    input  logic [fcct_pkg::RAW_W-1:0]      raw_in,
    output logic                            done,
    output logic [fcct_pkg::STATUS_W-1:0]   status,
    output logic [fcct_pkg::CL_W-1:0]       cluster_out,
    output logic [fcct_pkg::RAW_W-1:0]      raw_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam logic [fcct_pkg::LEN_W-1:0] DEPTH_LEN = fcct_pkg::LEN_W'(TABLE_ENTRIES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [fcct_pkg::CFG_W-1:0]     entries_reg;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [fcct_pkg::FUNC_W-1:0]    func_reg;
    logic [fcct_pkg::CL_W-1:0]      tg_reg;
    logic [fcct_pkg::RAW_W-1:0]     raw_reg;

    logic                           done_reg, done_next;
    logic [fcct_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [fcct_pkg::CL_W-1:0]      cout_reg, cout_next;
    logic [fcct_pkg::RAW_W-1:0]     rout_reg, rout_next;

    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [fcct_pkg::RAW_W-1:0]     mem_wdata, mem_rdata;

    logic [fcct_pkg::LEN_W-1:0]     len;
    logic                           accept;
    logic [fcct_pkg::CL_W-1:0]      v;
    logic [AW-1:0]                  idx_inc;
    logic [fcct_pkg::LEN_W-1:0]     idx_len, idx_inc_len;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign len = (fcct_pkg::LEN_W'(entries_reg) > DEPTH_LEN) ? DEPTH_LEN
                                                             : fcct_pkg::LEN_W'(entries_reg);

    assign v           = mem_rdata[fcct_pkg::CL_W-1:0];
    assign idx_inc     = idx_reg + AW'(1);
    assign idx_len     = fcct_pkg::LEN_W'(idx_reg);
    assign idx_inc_len = idx_len + fcct_pkg::LEN_W'(1);

    fcct_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = fcct_pkg::ST_OK;
        cout_next   = '0;
        rout_next   = '0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = cluster[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                idx_next = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == fcct_pkg::FN_ALLOC)
                    begin
                        if (len == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = fcct_pkg::ST_NONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (func == fcct_pkg::FN_UNUSED ||
                             fcct_pkg::LEN_W'(cluster) >= len)
                    begin
                        done_next   = 1'b1;
                        status_next = fcct_pkg::ST_RANGE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        idx_next   = cluster[AW-1:0];
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                mem_wdata  = mem_rdata & fcct_pkg::TOP4;
                case (func_reg)
                    fcct_pkg::FN_GET_NEXT:
                    begin
                        if (v == fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_BAD;
                        else if (v == fcct_pkg::FREE_MARK)
                            status_next = fcct_pkg::ST_FREE;
                        else if (v > fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_EOC;
                        else if (fcct_pkg::LEN_W'(v) >= len)
                            status_next = fcct_pkg::ST_RANGE;
                        else
                            cout_next = v;
                    end
                    fcct_pkg::FN_SET_NEXT:
                    begin
                        if (fcct_pkg::LEN_W'(tg_reg) >= len || tg_reg >= fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_RANGE;
                        else if (v == fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_BAD;
                        else if (v == fcct_pkg::FREE_MARK)
                            status_next = fcct_pkg::ST_FREE;
                        else if (v < fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_LINKED;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = (mem_rdata & fcct_pkg::TOP4) |
                                        fcct_pkg::RAW_W'(tg_reg);
                        end
                    end
                    fcct_pkg::FN_FINAL:
                    begin
                        if (v == fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_BAD;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = (mem_rdata & fcct_pkg::TOP4) |
                                        fcct_pkg::RAW_W'(fcct_pkg::LOW28);
                        end
                    end
                    fcct_pkg::FN_FREE:
                    begin
                        if (v == fcct_pkg::BAD_MARK)
                            status_next = fcct_pkg::ST_BAD;
                        else
                            mem_we = 1'b1;
                    end
                    fcct_pkg::FN_LOAD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = raw_reg;
                    end
                    default:
                    begin
                        rout_next = mem_rdata;
                    end
                endcase
            end
            S_SCAN:
            begin
                // rdata holds entry idx_reg; the next entry is fetched meanwhile
                mem_re    = 1'b1;
                mem_raddr = idx_inc;
                if (v == fcct_pkg::FREE_MARK)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    cout_next  = fcct_pkg::CL_W'(idx_reg);
                    if (idx_len < fcct_pkg::LEN_W'(2))
                    begin
                        status_next = fcct_pkg::ST_RESERVED;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = (mem_rdata & fcct_pkg::TOP4) |
                                    fcct_pkg::RAW_W'(fcct_pkg::LOW28);
                    end
                end
                else if (idx_inc_len >= len)
                begin
                    done_next   = 1'b1;
                    status_next = fcct_pkg::ST_NONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            entries_reg <= fcct_pkg::ENTRIES_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            tg_reg   <= target;
            raw_reg  <= raw_in;
        end
        if (done_next)
        begin
            status_reg <= status_next;
            cout_reg   <= cout_next;
            rout_reg   <= rout_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign cluster_out = cout_reg;
    assign raw_out     = rout_reg;

`ifndef NO_ASSERTIONS
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> done)
        else $error("single-entry transaction gave no result");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("ram written while idle");

    a_scan_skips_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_we) |-> (idx_reg >= AW'(2)))
        else $error("allocate wrote a reserved entry");

    a_reserved_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fcct_pkg::ST_RESERVED) |-> (cluster_out < fcct_pkg::CL_W'(2)))
        else $error("reserved status with index above one");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func != fcct_pkg::FN_UNUSED && len != '0 &&
         (func == fcct_pkg::FN_ALLOC || fcct_pkg::LEN_W'(cluster) < len)) |=> busy)
        else $error("ram transaction did not hold busy");
`endif

endmodule
